// ===== hdl/slid_pkg.sv =====
// Package for the sorted list engine.
// Holds the request and status codes and the command struct driven into each cell.
// No dependencies.
package slid_pkg;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	localparam int unsigned COUNT_BITS   = 5;
	localparam int unsigned RESULT_BITS  = 32;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== hdl/slid_cell.sv =====
// One storage cell of the sorted list chain.
// Holds one entry and loads the key or a neighbor entry on an insert or a delete.
// Depends on slid_pkg.
module slid_cell #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                          clk,
	input  slid_pkg::cell_cmd_t           cmd,
	input  logic                          occ,
	input  logic signed [VALUE_BITS-1:0]  key,
	input  logic signed [VALUE_BITS-1:0]  left_entry,
	input  logic                          left_gt,
	input  logic signed [VALUE_BITS-1:0]  right_entry,
	output logic signed [VALUE_BITS-1:0]  entry,
	output logic                          gt,
	output logic                          match
);
	import slid_pkg::*;

	logic signed [VALUE_BITS-1:0] entry_q;

	assign entry = entry_q;
	assign gt    = occ && (entry_q > key);
	assign match = occ && (entry_q == key);

	always_ff @(posedge clk) begin
		if (cmd.ins && !gt) begin
			if (left_gt) begin
				entry_q <= key;
			end else begin
				entry_q <= left_entry;
			end
		end else if (cmd.del && !gt) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/sorted_list_insert_delete_top.sv =====
// Top level of the sorted list engine: a chain of cells kept in descending order.
// Depends on slid_pkg and slid_cell.
//
// Usage:
// A request is taken at a rising clock edge where start is high and busy is low.
// req_type selects insert or delete of the first entry equal to value. Every
// cell compares its entry with the request value at once, and each cell whose
// entry is not greater shifts by one place toward or away from its neighbor, so
// each request finishes in the cycle it is taken. busy is always low and a new
// item may follow every cycle. The result appears in the cycle after acceptance:
// done is high for exactly one cycle with status, count and largest valid during
// that cycle. The rate is set by one compare per cell plus the match reduction
// across the chain. The receiver cannot stall, so no result is ever held back.
// An insert into a full list is dropped with status full; a delete reports
// empty or not found when nothing is removed. Reset clears the entry count and
// the done strobe; the cell contents are not cleared and are never shown while
// unused. count shows the low five bits of the entry count.
module sorted_list_insert_delete_top #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic signed [31:0]                  value,
	output logic                                done,
	output slid_pkg::status_t                   status,
	output logic [slid_pkg::COUNT_BITS-1:0]     count,
	output logic signed [31:0]                  largest
);
	import slid_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_BITS-1:0] key;
	logic signed [VALUE_BITS-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]          gt_w;
	logic [CAPACITY-1:0]          match_w;
	logic [CAPACITY-1:0]          occ_w;
	logic [CW-1:0]                used_q;
	logic                         accept;
	logic                         full;
	logic                         empty;
	logic                         found;
	cell_cmd_t                    cmd;
	status_t                      status_d;
	logic [CW-1:0]                used_d;
	logic                         done_q;
	status_t                      status_q;

	generate
		if (VALUE_BITS <= 32) begin : g_key_narrow
			assign key = value[VALUE_BITS-1:0];
			assign largest = (used_q != '0) ? 32'(entry_w[0]) : '0;
		end else begin : g_key_wide
			assign key = {{(VALUE_BITS-32){value[31]}}, value};
			assign largest = (used_q != '0) ? entry_w[0][31:0] : '0;
		end
	endgenerate

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (used_q == CW'(CAPACITY));
	assign empty  = (used_q == '0);
	assign found  = |match_w;

	always_comb begin
		cmd      = '0;
		status_d = ST_DONE;
		used_d   = used_q;
		unique case (req_t'(req_type))
			REQ_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins = accept;
					used_d  = used_q + CW'(1);
				end
			end
			REQ_DELETE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOT_FOUND;
				end else begin
					cmd.del = accept;
					used_d  = used_q - CW'(1);
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [VALUE_BITS-1:0] left_entry;
			logic                         left_gt;
			logic signed [VALUE_BITS-1:0] right_entry;

			assign occ_w[i] = (used_q > CW'(i));

			if (i == 0) begin : g_first
				assign left_entry = key;
				assign left_gt    = 1'b1;
			end else begin : g_mid
				assign left_entry = entry_w[i-1];
				assign left_gt    = gt_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign right_entry = entry_w[i];
			end else begin : g_inner
				assign right_entry = entry_w[i+1];
			end

			slid_cell #(
				.VALUE_BITS(VALUE_BITS)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ_w[i]),
				.key        (key),
				.left_entry (left_entry),
				.left_gt    (left_gt),
				.right_entry(right_entry),
				.entry      (entry_w[i]),
				.gt         (gt_w[i]),
				.match      (match_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				used_q <= used_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	assign done   = done_q;
	assign status = status_q;

	generate
		if (CW >= COUNT_BITS) begin : g_cnt_wide
			assign count = used_q[COUNT_BITS-1:0];
		end else begin : g_cnt_narrow
			assign count = COUNT_BITS'(used_q);
		end
	endgenerate

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted list engine (sorted_list_insert_delete_top).
// A directed table and a random phase drive inserts and deletes; every result is checked against a predictor,
// or against the table's own expected values where a row gives them. Depends on slid_pkg and the RTL of the engine.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slid_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1800;
	localparam logic signed [31:0] VMAX = 32'h7FFFFFFF;
	localparam logic signed [31:0] VMIN = 32'h80000000;

	typedef struct {
		status_t st;
		logic [COUNT_BITS-1:0] cnt;
		logic signed [31:0] top;
	} result_t;

	typedef struct {
		req_t req;
		logic signed [31:0] val;
		bit typed;
		status_t st;
		logic [COUNT_BITS-1:0] cnt;
		logic signed [31:0] top;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic req_type;
	logic signed [31:0] value;
	logic done;
	status_t status;
	logic [COUNT_BITS-1:0] count;
	logic signed [31:0] largest;

	logic signed [31:0] held_vals [CAPACITY];
	int held_count;
	result_t pending_results [$];
	bit typed_valid;
	result_t typed_exp;
	int fail_count;
	int cycles;

	sorted_list_insert_delete_top #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.status(status),
		.count(count),
		.largest(largest)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic result_t apply_request(req_t r, logic signed [31:0] v);
		result_t res;
		int pos;
		pos = 0;
		res.st = ST_DONE;
		if (r == REQ_INSERT) begin
			if (held_count >= CAPACITY) begin
				res.st = ST_FULL;
			end else begin
				while (pos < held_count && held_vals[pos] > v) pos++;
				for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
				held_vals[pos] = v;
				held_count++;
			end
		end else if (held_count == 0) begin
			res.st = ST_EMPTY;
		end else begin
			while (pos < held_count && held_vals[pos] != v) pos++;
			if (pos >= held_count) begin
				res.st = ST_NOT_FOUND;
			end else begin
				for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
				held_count--;
			end
		end
		res.cnt = held_count[COUNT_BITS-1:0];
		res.top = (held_count > 0) ? held_vals[0] : 32'sd0;
		return res;
	endfunction

	function automatic void note_fail(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want = apply_request(req_t'(req_type), value);
				if (typed_valid) want = typed_exp;
				pending_results.push_back(want);
			end
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					note_fail($sformatf("result with no item waiting: status %0d count %0d largest %0d",
						status, count, largest));
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st)
						note_fail($sformatf("status: expected %0d, got %0d", want.st, status));
					if (count !== want.cnt)
						note_fail($sformatf("count: expected %0d, got %0d", want.cnt, count));
					if (largest !== want.top)
						note_fail($sformatf("largest: expected %0d, got %0d", want.top, largest));
				end
			end else if (done !== 1'b0) begin
				note_fail("done strobe is unknown");
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(req_t r, logic signed [31:0] v, bit typed, result_t exp, int gap);
		@(negedge clk);
		start <= 1'b1;
		req_type <= r;
		value <= v;
		typed_valid <= typed;
		typed_exp <= exp;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value(bit prefer_held);
		logic signed [31:0] v;
		int sel;
		sel = $urandom_range(0, 9);
		if (prefer_held && held_count > 0 && $urandom_range(0, 9) < 7) sel = 9;
		case (sel)
			0, 1, 2, 3: v = $urandom_range(0, 20) - 10;
			4, 5: v = $urandom;
			6: begin
				case ($urandom_range(0, 3))
					0: v = VMAX;
					1: v = VMIN;
					2: v = 32'sd0;
					default: v = -32'sd1;
				endcase
			end
			default: v = (held_count > 0) ? held_vals[$urandom_range(0, held_count - 1)] : $urandom;
		endcase
		return v;
	endfunction

	dir_row_t dir_rows [25];
	result_t no_exp;
	int insert_pct [4] = '{85, 50, 20, 50};

	initial begin
		bit no_gaps;
		req_t r;
		int gap;
		result_t row_exp;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = 1'b0;
		value = 32'sd0;
		typed_valid = 1'b0;
		typed_exp = '{ST_DONE, '0, 32'sd0};
		no_exp = '{ST_DONE, '0, 32'sd0};
		held_count = 0;
		fail_count = 0;
		cycles = 0;
		dir_rows = '{
			'{REQ_DELETE, 32'sd5, 1'b1, ST_EMPTY, 5'd0, 32'sd0},
			'{REQ_INSERT, VMAX, 1'b1, ST_DONE, 5'd1, VMAX},
			'{REQ_INSERT, VMIN, 1'b1, ST_DONE, 5'd2, VMAX},
			'{REQ_DELETE, 32'sd5, 1'b1, ST_NOT_FOUND, 5'd2, VMAX},
			'{REQ_INSERT, 32'sd0, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd0, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_DELETE, VMAX, 1'b1, ST_DONE, 5'd3, 32'sd0},
			'{REQ_DELETE, VMIN, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, VMAX, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, VMIN, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, -32'sd1, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd1, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd100, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, -32'sd100, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sh40000000, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, -32'sh40000000, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd5, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd5, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, -32'sd5, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sh7FFFFFFE, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, -32'sh7FFFFFFF, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd2, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_INSERT, 32'sd3, 1'b1, ST_FULL, 5'd16, VMAX},
			'{REQ_DELETE, VMIN, 1'b0, ST_DONE, 5'd0, 32'sd0},
			'{REQ_DELETE, 32'sd0, 1'b0, ST_DONE, 5'd0, 32'sd0}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row_exp = '{dir_rows[i].st, dir_rows[i].cnt, dir_rows[i].top};
			send_item(dir_rows[i].req, dir_rows[i].val, dir_rows[i].typed, row_exp,
				$urandom_range(0, 4));
		end
		drain_results();

		no_gaps = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) no_gaps = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_ITEMS / 2) drain_results();
			r = ($urandom_range(0, 99) < insert_pct[(i / 100) % 4]) ? REQ_INSERT : REQ_DELETE;
			gap = no_gaps ? 0 : $urandom_range(0, 4);
			send_item(r, pick_value(r == REQ_DELETE), 1'b0, no_exp, gap);
		end
		drain_results();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
